FILE: rtl/core/npts_pkg.sv
// ----------------------------------------------------------------------------
// npts_pkg
// Shared widths, register indexes, reset values and types of the nearest path
// point search.
// ----------------------------------------------------------------------------
package npts_pkg;

  localparam int unsigned COORD_BITS     = 24;
  localparam int unsigned DIFF_W         = COORD_BITS + 1;
  localparam int unsigned SQ_W           = 2 * COORD_BITS;
  localparam int unsigned SUM_W          = SQ_W + 1;
  localparam int unsigned ROOT_W         = COORD_BITS + 1;
  localparam int unsigned DIST_W         = 26;
  localparam int unsigned OUT_W          = 12;
  localparam int unsigned TOL_W          = 10;
  localparam int unsigned GAP_W          = 4;

  localparam int unsigned MAX_POINTS_DEF  = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TOL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 2'd2;

  localparam logic             MODE_RST = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RST  = 10'd10;
  localparam logic [GAP_W-1:0] GAP_RST  = 4'd3;

  typedef struct packed {
    logic             mode;
    logic [TOL_W-1:0] tol;
    logic [GAP_W-1:0] gap;
  } cfg_t;

  // squared distance of one point with its scan marks
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             first;
    logic             last;
  } dist_req_t;

endpackage

FILE: rtl/core/npts_in_if.sv
// ----------------------------------------------------------------------------
// npts_in_if
// Path point channel: valid/ready handshake with point, query and scan marks.
// ----------------------------------------------------------------------------
interface npts_in_if;
  import npts_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic                         first_point;
  logic                         last_point;

  modport source (
    output valid, point_x, point_y, query_x, query_y, first_point, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, query_x, query_y, first_point, last_point,
    output ready
  );

endinterface

FILE: rtl/core/npts_out_if.sv
// ----------------------------------------------------------------------------
// npts_out_if
// Result channel: valid/ready handshake carrying the chosen point index.
// ----------------------------------------------------------------------------
interface npts_out_if;
  import npts_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] best_index;

  modport source (
    output valid, best_index,
    input  ready
  );

  modport sink (
    input  valid, best_index,
    output ready
  );

endinterface

FILE: rtl/core/npts_front.sv
// ----------------------------------------------------------------------------
// npts_front
// Accepts path points, holds the query, and forms the squared distance in a
// two-stage pipeline that feeds the queue.
// ----------------------------------------------------------------------------
module npts_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  npts_in_if.sink             in_i,
  output logic                req_valid_o,
  input  logic                req_ready_i,
  output npts_pkg::dist_req_t req_o
);
  import npts_pkg::*;

  logic signed [COORD_BITS-1:0] hqx_q, hqy_q;
  logic signed [COORD_BITS-1:0] qx, qy;
  logic signed [DIFF_W-1:0]     dx_d, dy_d, dx_q, dy_q;
  logic signed [2*DIFF_W-1:0]   prodx, prody;
  logic [SQ_W-1:0]              sqx_q, sqy_q;
  logic                         s1_v_q, s1_first_q, s1_last_q;
  logic                         s2_v_q, s2_first_q, s2_last_q;
  logic                         s1_rdy, s2_rdy, in_fire;

  assign s2_rdy     = !s2_v_q || req_ready_i;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_i.ready = s1_rdy;
  assign in_fire    = in_i.valid && s1_rdy;

  // a first point brings its own query, otherwise the held one applies
  assign qx   = in_i.first_point ? in_i.query_x : hqx_q;
  assign qy   = in_i.first_point ? in_i.query_y : hqy_q;
  assign dx_d = {in_i.point_x[COORD_BITS-1], in_i.point_x} - {qx[COORD_BITS-1], qx};
  assign dy_d = {in_i.point_y[COORD_BITS-1], in_i.point_y} - {qy[COORD_BITS-1], qy};

  assign prodx = dx_q * dx_q;
  assign prody = dy_q * dy_q;

  assign req_valid_o = s2_v_q;
  assign req_o.sum   = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign req_o.first = s2_first_q;
  assign req_o.last  = s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hqx_q      <= '0;
      hqy_q      <= '0;
      s1_v_q     <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      if (in_fire && in_i.first_point) begin
        hqx_q <= in_i.query_x;
        hqy_q <= in_i.query_y;
      end
      if (s1_rdy) begin
        s1_v_q     <= in_i.valid;
        s1_first_q <= in_i.first_point;
        s1_last_q  <= in_i.last_point;
      end
      if (s2_rdy) begin
        s2_v_q     <= s1_v_q;
        s2_first_q <= s1_first_q;
        s2_last_q  <= s1_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (s2_rdy) begin
      sqx_q <= prodx[SQ_W-1:0];
      sqy_q <= prody[SQ_W-1:0];
    end
  end

endmodule

FILE: rtl/core/npts_fifo.sv
// ----------------------------------------------------------------------------
// npts_fifo
// Short queue of squared distances between the front and the back.
// ----------------------------------------------------------------------------
module npts_fifo #(
  parameter int unsigned DEPTH = npts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  npts_pkg::dist_req_t wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output npts_pkg::dist_req_t rd_data_o
);
  import npts_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dist_req_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             wr_fire, rd_fire;

  assign wr_ready_o = (count_q != CNT_FULL);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      priority if (wr_fire && !rd_fire) begin
        count_q <= count_q + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count_q <= count_q - 1'b1;
      end else begin
        count_q <= count_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue fill count beyond depth");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_fire && !rd_fire) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue count missed a transfer in");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

FILE: rtl/core/npts_back.sv
// ----------------------------------------------------------------------------
// npts_back
// Integer square root, one result bit per cycle, then the compare and update
// of the chosen point and the result register.
// ----------------------------------------------------------------------------
module npts_back #(
  parameter int unsigned MAX_POINTS = npts_pkg::MAX_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  npts_pkg::cfg_t      cfg_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  npts_pkg::dist_req_t req_i,
  npts_out_if.source          out_o
);
  import npts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W = (IDX_W > GAP_W) ? IDX_W : GAP_W;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_POINTS - 1);
  localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (SUM_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_UPD
  } state_e;

  state_e            st_q;
  logic [SUM_W-1:0]  n_q, res_q, bit_q, trial;
  logic              first_q, last_q;
  logic [DIST_W-1:0] min_q, min_eff, pt_dist;
  logic [DIST_W:0]   lim;
  logic [IDX_W-1:0]  chosen_q, cnt_q, chosen_eff, idx;
  logic              out_v_q;
  logic [OUT_W-1:0]  best_q;
  logic              ge, gap_ok, take, out_free, upd_go, res_go;

  assign trial   = res_q + bit_q;
  assign ge      = (n_q >= trial);
  assign pt_dist = DIST_W'(res_q[ROOT_W-1:0]);

  // a first point restarts the scan before it is scored
  assign min_eff    = first_q ? '1 : min_q;
  assign chosen_eff = first_q ? '0 : chosen_q;
  assign idx        = first_q ? '0 : cnt_q;

  assign lim    = {1'b0, min_eff} + (DIST_W + 1)'(cfg_i.tol);
  assign gap_ok = CMP_W'(idx - chosen_eff) > CMP_W'(cfg_i.gap);
  assign take   = cfg_i.mode ? (({1'b0, pt_dist} < lim) && gap_ok) : (pt_dist < min_eff);

  assign out_free = !out_v_q || out_o.ready;
  assign upd_go   = !last_q || out_free;
  assign res_go   = (st_q == ST_UPD) && last_q && upd_go;

  assign req_ready_o      = (st_q == ST_IDLE);
  assign out_o.valid      = out_v_q;
  assign out_o.best_index = best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      n_q      <= '0;
      res_q    <= '0;
      bit_q    <= '0;
      first_q  <= 1'b0;
      last_q   <= 1'b0;
      min_q    <= '1;
      chosen_q <= '0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
      best_q   <= '0;
    end else begin
      if (out_v_q && out_o.ready && !res_go) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            n_q     <= req_i.sum;
            res_q   <= '0;
            bit_q   <= BIT_START;
            first_q <= req_i.first;
            last_q  <= req_i.last;
            st_q    <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (ge) begin
            n_q   <= n_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            st_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            if (last_q) begin
              out_v_q  <= 1'b1;
              best_q   <= take ? OUT_W'(idx) : OUT_W'(chosen_eff);
              min_q    <= '1;
              chosen_q <= '0;
              cnt_q    <= '0;
            end else begin
              if (take) begin
                min_q    <= pt_dist;
                chosen_q <= idx;
              end else begin
                min_q    <= min_eff;
                chosen_q <= chosen_eff;
              end
              cnt_q <= (idx < IDX_LAST) ? idx + 1'b1 : idx;
            end
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_UPD) |-> (res_q[SUM_W-1:ROOT_W] == '0))
    else $error("square root wider than the distance");

  a_chosen_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chosen_q <= cnt_q)
    else $error("chosen index ahead of point counter");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past((st_q == ST_UPD) && last_q))
    else $error("result raised outside a last point update");

endmodule

FILE: rtl/core/path_nearest_point_search.sv
// ----------------------------------------------------------------------------
// path_nearest_point_search
// Nearest path point search over a stream of points with configurable mode.
// ----------------------------------------------------------------------------
// In the back end each path point is picked from the queue, goes through the
// integer square root (one result bit per cycle in a single shared root unit),
// then the compare and update, which on a scan's last point waits for a free
// output register; a new point is taken only once the last is done. The front
// end takes points in every cycle until its two pipeline stages and the
// QUEUE_DEPTH-entry queue are full, so a burst of up to QUEUE_DEPTH + 3 points
// goes in without stalls. The update of a scan's last point loads its result,
// which waits in an output register. Configuration writes take effect at once;
// the user must make them while no point is in flight, as the block won't check.
module path_nearest_point_search #(
  parameter int unsigned MAX_POINTS  = npts_pkg::MAX_POINTS_DEF,
  parameter int unsigned QUEUE_DEPTH = npts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  npts_in_if.sink                            in_i,
  npts_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [npts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [npts_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import npts_pkg::*;

  cfg_t      cfg_q;
  logic      fr_valid, fr_ready, bk_valid, bk_ready;
  dist_req_t fr_req, bk_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_RST;
      cfg_q.tol  <= TOL_RST;
      cfg_q.gap  <= GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE: cfg_q.mode <= cfg_data_i[0];
        CFG_TOL:  cfg_q.tol  <= cfg_data_i[TOL_W-1:0];
        CFG_GAP:  cfg_q.gap  <= cfg_data_i[GAP_W-1:0];
        default:  cfg_q      <= cfg_q;
      endcase
    end
  end

  npts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_valid_o (fr_valid),
    .req_ready_i (fr_ready),
    .req_o       (fr_req)
  );

  npts_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_req),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_req)
  );

  npts_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (bk_valid),
    .req_ready_o (bk_ready),
    .req_i       (bk_req),
    .out_o       (out_o)
  );

endmodule

FILE: tb/npts_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npts_tb_pkg
// Search mode codes shared by the stimulus and the checker of the nearest
// path point search testbench.
// ----------------------------------------------------------------------------
package npts_tb_pkg;

  localparam logic MODE_STRICT  = 1'b0;
  localparam logic MODE_FORWARD = 1'b1;

endpackage

FILE: tb/npts_nearest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npts_nearest_checker
// Watches the point and index channels and the register port, predicts the
// chosen index of every scan and compares it with each index transfer.
// ----------------------------------------------------------------------------
module npts_nearest_checker
  import npts_pkg::*;
  import npts_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  npts_in_if                    pts_i,
  npts_out_if                   idx_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam logic [DIST_W-1:0] NO_DIST  = '1;
  localparam logic [OUT_W-1:0]  LAST_IDX = OUT_W'(MAX_POINTS_DEF - 1);

  logic             mode_q;
  logic [TOL_W-1:0] tol_q;
  logic [GAP_W-1:0] gap_q;

  logic [DIST_W-1:0] nearest_dist;
  logic [OUT_W-1:0]  chosen_idx;
  logic [OUT_W-1:0]  next_idx;
  coord_t            anchor_x;
  coord_t            anchor_y;

  logic [OUT_W-1:0] expected_idx_q[$];
  int unsigned      outstanding;
  int unsigned      mismatch_count;

  assign pending_o = outstanding;
  assign errors_o  = mismatch_count;

  // floor square root of the squared distance, found bit by bit from the top
  function automatic logic [DIST_W-1:0] floor_distance(input coord_t px, input coord_t py,
                                                       input coord_t qx, input coord_t qy);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    dx   = longint'(px) - longint'(qx);
    dy   = longint'(py) - longint'(qy);
    sq   = longint'(dx * dx) + longint'(dy * dy);
    root = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  task automatic clear_scan();
    nearest_dist = NO_DIST;
    chosen_idx   = '0;
    next_idx     = '0;
  endtask

  task automatic advance_scan(input coord_t px, input coord_t py, input coord_t qx,
                              input coord_t qy, input logic first_mark,
                              input logic last_mark);
    logic [DIST_W-1:0] pt_dist;
    logic              take;
    int unsigned       slack;
    if (first_mark) begin
      clear_scan();
      anchor_x = qx;
      anchor_y = qy;
    end
    pt_dist = floor_distance(px, py, anchor_x, anchor_y);
    slack   = 32'(nearest_dist) + 32'(tol_q);
    if (mode_q == MODE_STRICT) begin
      take = pt_dist < nearest_dist;
    end else begin
      take = (32'(pt_dist) < slack) && (32'(next_idx - chosen_idx) > 32'(gap_q));
    end
    if (take) begin
      nearest_dist = pt_dist;
      chosen_idx   = next_idx;
    end
    // later points of a long path share the top index
    if (next_idx != LAST_IDX) next_idx++;
    if (last_mark) begin
      expected_idx_q.push_back(chosen_idx);
      outstanding++;
      clear_scan();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      mode_q   = MODE_RST;
      tol_q    = TOL_RST;
      gap_q    = GAP_RST;
      anchor_x = '0;
      anchor_y = '0;
      clear_scan();
      expected_idx_q.delete();
      outstanding    = 0;
      mismatch_count = 0;
    end else begin
      if (idx_i.valid && idx_i.ready) begin
        if (expected_idx_q.size() == 0) begin
          $error("best_index transfer with nothing expected: actual %0d", idx_i.best_index);
          mismatch_count++;
        end else begin
          want = expected_idx_q.pop_front();
          outstanding--;
          if (idx_i.best_index !== want) begin
            $error("best_index mismatch: expected %0d, actual %0d", want, idx_i.best_index);
            mismatch_count++;
          end
        end
      end
      if (pts_i.valid && pts_i.ready) begin
        advance_scan(pts_i.point_x, pts_i.point_y, pts_i.query_x, pts_i.query_y,
                     pts_i.first_point, pts_i.last_point);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode_q = cfg_data_i[0];
          CFG_TOL:  tol_q  = cfg_data_i[TOL_W-1:0];
          CFG_GAP:  gap_q  = cfg_data_i[GAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: tb/path_nearest_point_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_nearest_point_search_tb
// Streams directed and random path scans through the search under several
// register settings, with bursty input, a stalling result side and one long
// hold-off; the checker predicts every chosen index and counts mismatches.
// ----------------------------------------------------------------------------
module path_nearest_point_search_tb;
  import npts_pkg::*;
  import npts_tb_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_START    = 6000;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned RANDOM_POINTS = 750;
  localparam int unsigned SEGMENTS      = 6;
  localparam longint     TIMEOUT_NS    = 20_000_000;

  localparam coord_t C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           scan_pending;
  int unsigned           scan_errors;

  int unsigned burst_left;
  bit          gaps_on;
  int unsigned points_sent;

  npts_in_if  pts_if ();
  npts_out_if idx_if ();

  path_nearest_point_search u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pts_if),
    .out_o      (idx_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  npts_nearest_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pts_i      (pts_if),
    .idx_i      (idx_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (scan_pending),
    .errors_o   (scan_errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  // one point transfer; bursts of random length with random gaps between them
  task automatic send_point(input coord_t px, input coord_t py, input coord_t qx,
                            input coord_t qy, input logic first_mark, input logic last_mark);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = gaps_on ? $urandom_range(0, 40) : 0;
      if (gap != 0) begin
        @(negedge clk_i);
        pts_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    pts_if.valid       = 1'b1;
    pts_if.point_x     = px;
    pts_if.point_y     = py;
    pts_if.query_x     = qx;
    pts_if.query_y     = qy;
    pts_if.first_point = first_mark;
    pts_if.last_point  = last_mark;
    @(posedge clk_i);
    while (!pts_if.ready) @(posedge clk_i);
    points_sent++;
  endtask

  task automatic axis_point(input int x, input logic first_mark, input logic last_mark);
    send_point(coord_t'(x), '0, '0, '0, first_mark, last_mark);
  endtask

  // let every expected index arrive, then give the back end time to empty
  task automatic quiesce();
    @(negedge clk_i);
    pts_if.valid = 1'b0;
    wait (scan_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(0, 9))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t near_coord(input coord_t centre, input int unsigned spread);
    return centre + coord_t'(int'($urandom_range(0, 2 * spread)) - int'(spread));
  endfunction

  // restart_at equal to len means no mid-scan restart
  task automatic random_scan(input int unsigned len, input logic headed, input logic closed,
                             input int unsigned restart_at, input logic noisy);
    coord_t      qx;
    coord_t      qy;
    coord_t      px;
    coord_t      py;
    int unsigned spread;
    logic        first_mark;
    logic        last_mark;
    qx     = any_coord();
    qy     = any_coord();
    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 20) : $urandom_range(0, 64);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        px = any_coord();
        py = any_coord();
      end else begin
        px = near_coord(qx, spread);
        py = near_coord(qy, spread);
      end
      if (noisy) begin
        first_mark = ($urandom_range(0, 3) == 0);
        last_mark  = ($urandom_range(0, 3) == 0);
      end else begin
        first_mark = (headed && i == 0) || i == restart_at;
        last_mark  = closed && i == len - 1;
      end
      if (first_mark) send_point(px, py, qx, qy, first_mark, last_mark);
      else            send_point(px, py, any_coord(), any_coord(), first_mark, last_mark);
    end
  endtask

  // result side: changing stall patterns, one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned style;
    cyc   = 0;
    style = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == HOLD_START) begin
        idx_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (cyc % 400 == 0) style = $urandom_range(0, 3);
        case (style)
          0:       idx_if.ready = 1'b1;
          1:       idx_if.ready = 1'($urandom_range(0, 1));
          2:       idx_if.ready = ($urandom_range(0, 3) == 0);
          default: idx_if.ready = (cyc % 9) >= 4;
        endcase
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned tol;
    int unsigned gap;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_MODE;
    cfg_data           = '0;
    pts_if.valid       = 1'b0;
    pts_if.point_x     = '0;
    pts_if.point_y     = '0;
    pts_if.query_x     = '0;
    pts_if.query_y     = '0;
    pts_if.first_point = 1'b0;
    pts_if.last_point  = 1'b0;
    idx_if.ready       = 1'b0;
    burst_left         = 0;
    gaps_on            = 1'b1;
    points_sent        = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: strict nearest
    // opposite corners, alone in their scan
    send_point(C_MAX, C_MIN, C_MIN, C_MAX, 1'b1, 1'b1);
    // scan without a first mark runs against the held query
    send_point(coord_t'(5), coord_t'(5), '0, '0, 1'b0, 1'b0);
    send_point(coord_t'(-3), coord_t'(4), C_MAX, C_MIN, 1'b0, 1'b0);
    send_point('0, '0, '0, '0, 1'b0, 1'b1);
    // equal distances: the earlier point is kept
    send_point(coord_t'(1100), coord_t'(-1000), coord_t'(1000), coord_t'(-1000), 1'b1, 1'b0);
    send_point(coord_t'(1000), coord_t'(-950), C_MIN, C_MAX, 1'b0, 1'b0);
    send_point(coord_t'(1000), coord_t'(-1050), '1, '0, 1'b0, 1'b0);
    send_point(coord_t'(1070), coord_t'(-1000), '0, '1, 1'b0, 1'b1);
    // a second first mark restarts the scan
    axis_point(10, 1'b1, 1'b0);
    axis_point(3, 1'b0, 1'b0);
    send_point(coord_t'(7), coord_t'(7), coord_t'(7), coord_t'(7), 1'b1, 1'b0);
    send_point(coord_t'(9), coord_t'(9), '0, '0, 1'b0, 1'b1);
    quiesce();

    write_reg(CFG_MODE, MODE_FORWARD);
    write_reg(CFG_TOL, 1023);
    write_reg(CFG_GAP, 0);
    send_point(coord_t'(1), coord_t'(1), coord_t'(-1), coord_t'(-1), 1'b1, 1'b1);
    axis_point(100, 1'b1, 1'b0);
    axis_point(200, 1'b0, 1'b0);
    axis_point(90, 1'b0, 1'b0);
    axis_point(1200, 1'b0, 1'b0);
    axis_point(50, 1'b0, 1'b1);
    quiesce();

    write_reg(CFG_TOL, 0);
    write_reg(CFG_GAP, 1);
    axis_point(40, 1'b1, 1'b0);
    axis_point(30, 1'b0, 1'b0);
    axis_point(30, 1'b0, 1'b0);
    axis_point(20, 1'b0, 1'b0);
    axis_point(25, 1'b0, 1'b1);

    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      quiesce();
      case (seg)
        1: begin
          tol = 0;
          gap = 15;
        end
        3: begin
          tol = 1023;
          gap = 0;
        end
        default: begin
          tol = $urandom_range(0, 1023);
          gap = $urandom_range(0, 15);
        end
      endcase
      write_reg(CFG_MODE, (seg % 2 == 1) ? MODE_FORWARD : MODE_STRICT);
      write_reg(CFG_TOL, tol);
      write_reg(CFG_GAP, gap);
      gaps_on     = (seg != 2);
      points_sent = 0;
      while (points_sent < RANDOM_POINTS / SEGMENTS) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
          random_scan(len, 1'b1, 1'b1, len, 1'b0);
        end else if (kind == 7) begin
          len = $urandom_range(1, 10);
          random_scan(len, 1'b0, 1'b1, len, 1'b0);
        end else if (kind == 8) begin
          len = $urandom_range(3, 20);
          random_scan(len, 1'b1, 1'b1, $urandom_range(1, len - 1), 1'b0);
        end else begin
          random_scan($urandom_range(1, 6), 1'b0, 1'b0, 0, 1'b1);
        end
      end
    end
    quiesce();

    if (scan_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
